### sv/sha_pkg.sv
package sha_pkg;

    typedef struct packed {
        logic [63:0] message_word;
        logic [3:0]  byte_count;
        logic        final_word;
    } t_in;

    typedef struct packed {
        logic [63:0] digest_word;
        logic        digest_last;
    } t_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } t_state;

    typedef logic [63:0] t_hash [8];

    localparam logic [63:0] IV_512 [8] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
        64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};

    localparam logic [63:0] IV_384 [8] = '{
        64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17,
        64'h152fecd8f70e5939, 64'h67332667ffc00b31, 64'h8eb44a8768581511,
        64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4};

    localparam logic [63:0] ROUND_K [80] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};

    function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
        rotr = (x >> n) | (x << (64 - n));
    endfunction

endpackage

### sv/sha512_sha384_hash_unit.sv
// Channel   | Direction | Handshake          | Payload
// input     | in        | i_valid / o_ready  | t_in  (message_word, byte_count, final_word)
// output    | out       | o_valid / i_ready  | t_out (digest_word, digest_last)
// config    | in        | i_cfg_we           | i_cfg_data[0] = mode_384
//
// A non-final word is stored in the block and, if it fills the block, starts a compression;
// a full block passes through a load state, 80 rounds on one shared round unit and an add state.
// A final word adds padding writes, one or two compressions, and one digest word
// per cycle while i_ready is high.
// Reset is synchronous and active low and loads the SHA-512 initial value.
// The input is not ready while a block compresses, pads, or the digest drains.
module sha512_sha384_hash_unit
    import sha_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in         i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out        o_data,
    input  logic        i_cfg_we,
    input  logic        i_cfg_data
);
    t_state r_state, n_state;
    logic        r_mode;
    t_hash       r_hash;
    logic [63:0] r_blk [16];
    logic [63:0] r_win [16];
    logic [63:0] r_v [8];
    logic [3:0]  r_pos;
    logic [63:0] r_bytes;
    logic [6:0]  r_round;
    logic        r_final;   // message padding is in progress
    logic        r_lenpad;  // the 0x80 pad byte has been placed
    logic        r_spill;   // the pad word sits in slot 14, so the length moves on
    logic        r_done;    // the length word has been written
    logic [2:0]  r_oidx;

    logic [63:0] new_a, new_e, next_w, w_cur;
    logic [3:0]  nbytes;
    logic [63:0] keep, padw;
    logic [2:0]  last_idx;
    logic        in_xfer;

    assign last_idx = r_mode ? 3'd5 : 3'd7;
    assign o_ready  = (r_state == ST_IDLE);
    assign in_xfer  = i_valid && o_ready;
    assign o_valid  = (r_state == ST_OUT);
    assign o_data.digest_word = r_hash[r_oidx];
    assign o_data.digest_last = (r_oidx == last_idx);

    // Rounds 0..15 use the block words directly; later rounds use the new word.
    assign w_cur = (r_round < 7'd16) ? r_win[r_round[3:0]] : next_w;

    sha_round u_round (
        .i_a(r_v[0]), .i_b(r_v[1]), .i_c(r_v[2]), .i_d(r_v[3]),
        .i_e(r_v[4]), .i_f(r_v[5]), .i_g(r_v[6]), .i_h(r_v[7]),
        .i_k(ROUND_K[r_round]),
        .i_w(w_cur),
        .i_w2(r_win[4'(r_round[3:0] - 4'd2)]),
        .i_w7(r_win[4'(r_round[3:0] - 4'd7)]),
        .i_w15(r_win[4'(r_round[3:0] - 4'd15)]),
        .i_w16(r_win[r_round[3:0]]),
        .o_new_a(new_a), .o_new_e(new_e), .o_next_w(next_w)
    );

    always_comb begin
        nbytes = (i_data.byte_count > 4'd8) ? 4'd8 : i_data.byte_count;
        keep = (nbytes == 4'd0) ? 64'd0 : ~(64'hffffffffffffffff >> (7'(nbytes) * 7'd8));
        padw = (i_data.message_word & keep) | (64'h80 << (7'd56 - 7'(nbytes) * 7'd8));
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (in_xfer) begin
                if (i_data.final_word) begin
                    n_state = (r_pos == 4'd15) ? ST_LOAD : ST_PAD;
                end else if (r_pos == 4'd15) begin
                    n_state = ST_LOAD;
                end
            end
            ST_PAD:   if (r_pos == 4'd15) n_state = ST_LOAD;
            ST_LOAD:  n_state = ST_ROUND;
            ST_ROUND: if (r_round == 7'd79) n_state = ST_ADD;
            ST_ADD:   n_state = !r_final ? ST_IDLE : (r_done ? ST_OUT : ST_PAD);
            ST_OUT:   if (i_ready && r_oidx == last_idx) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_mode  <= 1'b0;
            r_hash  <= IV_512;
            r_pos   <= '0;
            r_bytes <= '0;
            r_round <= '0;
            r_final <= 1'b0;
            r_lenpad <= 1'b0;
            r_spill <= 1'b0;
            r_done  <= 1'b0;
            r_oidx  <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_mode  <= i_cfg_data;
                r_hash  <= i_cfg_data ? IV_384 : IV_512;
                r_pos   <= '0;
                r_bytes <= '0;
            end else begin
                unique case (r_state)
                    ST_IDLE: if (in_xfer) begin
                        r_pos <= r_pos + 4'd1;
                        if (!i_data.final_word) begin
                            r_blk[r_pos] <= i_data.message_word;
                            r_bytes <= r_bytes + 64'd8;
                        end else begin
                            r_final <= 1'b1;
                            r_bytes <= r_bytes + 64'(nbytes);
                            if (nbytes == 4'd8) begin
                                // The pad byte goes into the following word.
                                r_blk[r_pos] <= i_data.message_word;
                                r_lenpad <= 1'b0;
                            end else begin
                                r_blk[r_pos] <= padw;
                                r_lenpad <= 1'b1;  // marker: pad byte already placed
                                r_spill  <= (r_pos == 4'd14);
                            end
                        end
                    end
                    ST_PAD: begin
                        // r_lenpad low means the 0x80 word is still owed.
                        r_pos <= r_pos + 4'd1;
                        if (!r_lenpad) begin
                            r_blk[r_pos] <= 64'h8000000000000000;
                            r_lenpad <= 1'b1;
                            r_spill  <= (r_pos == 4'd14);
                        end else if (r_pos == 4'd15 && !r_spill) begin
                            r_blk[r_pos] <= {r_bytes[60:0], 3'b000};
                            r_done <= 1'b1;
                        end else begin
                            r_blk[r_pos] <= 64'd0;
                        end
                    end
                    ST_LOAD: begin
                        r_win <= r_blk;
                        for (int i = 0; i < 8; i++) r_v[i] <= r_hash[i];
                        r_round <= '0;
                        r_spill <= 1'b0;
                    end
                    ST_ROUND: begin
                        if (r_round >= 7'd16) r_win[r_round[3:0]] <= next_w;
                        r_v[0] <= new_a; r_v[1] <= r_v[0]; r_v[2] <= r_v[1]; r_v[3] <= r_v[2];
                        r_v[4] <= new_e; r_v[5] <= r_v[4]; r_v[6] <= r_v[5]; r_v[7] <= r_v[6];
                        r_round <= r_round + 7'd1;
                    end
                    ST_ADD: begin
                        for (int i = 0; i < 8; i++) r_hash[i] <= r_hash[i] + r_v[i];
                        r_round <= '0;
                        r_oidx  <= '0;
                    end
                    ST_OUT: if (i_ready) begin
                        r_oidx <= r_oidx + 3'd1;
                        if (r_oidx == last_idx) begin
                            r_hash  <= r_mode ? IV_384 : IV_512;
                            r_pos   <= '0;
                            r_bytes <= '0;
                            r_final <= 1'b0;
                            r_lenpad <= 1'b0;
                            r_spill <= 1'b0;
                            r_done  <= 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end
    // Note: ST_ADD returns to ST_PAD until the length word has been written, which
    // r_done records. A pad word in slot 14 leaves no room for the length, so r_spill
    // turns slot 15 into a zero word and the length goes into the next block.

`ifndef SYNTHESIS
    a_ready_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !o_valid) else $error("ready while digest pending");
    a_round_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND) |-> (r_round < 7'd80)) else $error("round overrun");
    a_round_to_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND && r_round == 7'd79) |=> (r_state == ST_ADD))
        else $error("round count lost");
`endif
endmodule

### sv/sha_round.sv
module sha_round
    import sha_pkg::*;
(
    input  logic [63:0] i_a, i_b, i_c, i_d, i_e, i_f, i_g, i_h,
    input  logic [63:0] i_k,
    input  logic [63:0] i_w,
    input  logic [63:0] i_w2, i_w7, i_w15, i_w16,
    output logic [63:0] o_new_a,
    output logic [63:0] o_new_e,
    output logic [63:0] o_next_w
);
    logic [63:0] t1, t2, s0, s1;

    // Schedule word for round t+16 from the sliding window, and the round's new a and e.
    always_comb begin
        s1 = rotr(i_w2, 19) ^ rotr(i_w2, 61) ^ (i_w2 >> 6);
        s0 = rotr(i_w15, 1) ^ rotr(i_w15, 8) ^ (i_w15 >> 7);
        o_next_w = s1 + i_w7 + s0 + i_w16;
        t1 = i_h + (rotr(i_e, 14) ^ rotr(i_e, 18) ^ rotr(i_e, 41))
            + ((i_e & i_f) ^ (~i_e & i_g)) + i_k + i_w;
        t2 = (rotr(i_a, 28) ^ rotr(i_a, 34) ^ rotr(i_a, 39))
            + ((i_a & i_b) ^ (i_a & i_c) ^ (i_b & i_c));
        o_new_a = t1 + t2;
        o_new_e = i_d + t1;
    end
endmodule

### test/testbench.sv
module testbench
    import sha_pkg::*;
();

    // Clock, reset and the block's ports. Every input starts at a known value.
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    t_in  i_data = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    t_out o_data;
    logic i_cfg_we = 1'b0;
    logic i_cfg_data = 1'b0;

    sha512_sha384_hash_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Local copy of the hasher state, advanced once per accepted input word.
    logic [63:0] chain_hash [8];
    logic [63:0] pending_block [16];
    logic [3:0]  fill_pos;
    logic [63:0] byte_total;
    logic        sel_384;

    // Expected digest words, oldest first.
    t_out digest_queue [$];

    int  error_count = 0;
    int  idle_cycles = 0;
    bit  done_sending = 1'b0;
    localparam int WATCHDOG_LIMIT = 20000;

    function automatic logic [63:0] ror64(logic [63:0] x, int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    // Loads the initial value of the selected variant and restarts the message.
    function automatic void restart_message();
        for (int i = 0; i < 8; i++)
            chain_hash[i] = sel_384 ? IV_384[i] : IV_512[i];
        fill_pos = '0;
        byte_total = '0;
    endfunction

    // One 80-round compression of the gathered block into the chaining value.
    function automatic void compress_block();
        logic [63:0] w [16];
        logic [63:0] v [8];
        logic [63:0] s0, s1, t1, t2;
        for (int i = 0; i < 16; i++) w[i] = pending_block[i];
        for (int i = 0; i < 8; i++) v[i] = chain_hash[i];
        for (int t = 0; t < 80; t++) begin
            if (t >= 16) begin
                s1 = ror64(w[(t-2)&15], 19) ^ ror64(w[(t-2)&15], 61) ^ (w[(t-2)&15] >> 6);
                s0 = ror64(w[(t-15)&15], 1) ^ ror64(w[(t-15)&15], 8) ^ (w[(t-15)&15] >> 7);
                w[t&15] = s1 + w[(t-7)&15] + s0 + w[t&15];
            end
            t1 = v[7] + (ror64(v[4], 14) ^ ror64(v[4], 18) ^ ror64(v[4], 41))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[t] + w[t&15];
            t2 = (ror64(v[0], 28) ^ ror64(v[0], 34) ^ ror64(v[0], 39))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) chain_hash[i] += v[i];
    endfunction

    function automatic void append_word(logic [63:0] w);
        pending_block[fill_pos] = w;
        fill_pos++;
        if (fill_pos == 0) compress_block();
    endfunction

    // Advances the model by one input word and queues any digest it produces.
    function automatic void predict_digest(t_in item);
        logic [3:0]  n;
        logic [63:0] keep;
        logic [63:0] bits;
        int          count;
        t_out        res;
        if (!item.final_word) begin
            byte_total += 8;
            append_word(item.message_word);
            return;
        end
        n = (item.byte_count > 8) ? 4'd8 : item.byte_count;
        byte_total += n;
        bits = byte_total << 3;
        if (n == 8) begin
            append_word(item.message_word);
            append_word(64'h80 << 56);
        end else begin
            keep = (n == 0) ? 64'd0 : ~64'd0 << (64 - 8 * n);
            append_word((item.message_word & keep) | (64'h80 << (56 - 8 * n)));
        end
        if (fill_pos > 14) begin
            while (fill_pos != 0) append_word('0);
        end
        while (fill_pos < 14) append_word('0);
        append_word('0);
        append_word(bits);
        count = sel_384 ? 6 : 8;
        for (int k = 0; k < count; k++) begin
            res.digest_word = chain_hash[k];
            res.digest_last = (k == count - 1);
            digest_queue = {digest_queue, res};
        end
        restart_message();
    endfunction

    // Mostly short gaps, now and then a long one, sometimes none at all.
    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic idle_for(int n);
        repeat (n) @(posedge i_clk);
    endtask

    // Drives one input word and holds it until its transfer completes.
    // Valid stays high after the transfer when the next word follows at once.
    task automatic send_word(t_in item);
        int gap;
        gap = gap_length();
        if (gap > 0) begin
            i_valid <= 1'b0;
            idle_for(gap);
        end
        i_valid <= 1'b1;
        i_data  <= item;
        do @(posedge i_clk); while (!o_ready);
        predict_digest(item);
    endtask

    // Waits for every expected digest word, then for the block to settle.
    task automatic drain_block();
        i_valid <= 1'b0;
        while (digest_queue.size() != 0) @(posedge i_clk);
        idle_for(100);
    endtask

    // Mode writes happen only while the block is idle.
    task automatic write_mode(logic mode);
        drain_block();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= mode;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sel_384 = mode;
        restart_message();
        idle_for(2);
    endtask

    // Sends a message of full words followed by one final word.
    task automatic send_message(int full_words, int tail_bytes, bit random_junk);
        t_in item;
        for (int i = 0; i < full_words; i++) begin
            item.message_word = {$urandom, $urandom};
            item.byte_count   = random_junk ? 4'($urandom) : 4'd8;
            item.final_word   = 1'b0;
            send_word(item);
        end
        item.message_word = {$urandom, $urandom};
        item.byte_count   = 4'(tail_bytes);
        item.final_word   = 1'b1;
        send_word(item);
    endtask

    // Receiver side: random backpressure and an in-order check of each transfer.
    initial begin
        t_out want;
        int   stall;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (o_valid && i_ready) begin
                if (digest_queue.size() == 0) begin
                    $display("%0t: unexpected digest word %h last %b", $realtime,
                             o_data.digest_word, o_data.digest_last);
                    error_count++;
                end else begin
                    want = digest_queue.pop_front();
                    if (o_data.digest_word !== want.digest_word) begin
                        $display("%0t: digest_word expected %h actual %h", $realtime,
                                 want.digest_word, o_data.digest_word);
                        error_count++;
                    end
                    if (o_data.digest_last !== want.digest_last) begin
                        $display("%0t: digest_last expected %b actual %b", $realtime,
                                 want.digest_last, o_data.digest_last);
                        error_count++;
                    end
                end
            end
            if (stall > 0) begin
                i_ready <= 1'b0;
                stall--;
            end else begin
                i_ready <= 1'b1;
                stall = ($urandom_range(0, 2) == 0) ? gap_length() : 0;
            end
        end
    end

    // Watchdog: before sending is done, any cycle without a transfer or a mode write counts toward the limit.
    initial begin
        forever begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready) || i_cfg_we || done_sending)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Directed: an empty message, every tail length, and the padding boundary.
    task automatic test_tail_lengths();
        send_message(0, 0, 1'b0);
        for (int n = 1; n <= 8; n++) send_message(n % 3, n, 1'b0);
        send_message(0, 15, 1'b0);
        send_message(1, 9, 1'b1);
    endtask

    // Directed: messages whose padding crosses into a second block, then two one-word messages.
    task automatic test_block_boundaries();
        t_in item;
        send_message(13, 8, 1'b0);
        send_message(14, 0, 1'b0);
        send_message(15, 3, 1'b0);
        item.message_word = '1;
        item.byte_count   = 4'd8;
        item.final_word   = 1'b1;
        send_word(item);
        item.message_word = '0;
        send_word(item);
    endtask

    // Directed: a mode write abandons a message that is half sent.
    task automatic test_abandon();
        t_in item;
        item.message_word = {$urandom, $urandom};
        item.byte_count   = 4'd8;
        item.final_word   = 1'b0;
        send_word(item);
        send_word(item);
        write_mode(~sel_384);
        send_message(2, 5, 1'b0);
    endtask

    // Random messages, mostly short with an occasional multi-block one.
    task automatic test_random_messages(int words);
        int sent;
        int len;
        sent = 0;
        while (sent < words) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 40)
                                              : $urandom_range(0, 6);
            send_message(len, $urandom_range(0, 15), $urandom_range(0, 1));
            sent += len + 1;
        end
    endtask

    initial begin
        idle_for(10);
        i_rst_n <= 1'b1;
        sel_384 = 1'b0;
        restart_message();
        @(posedge i_clk);

        test_tail_lengths();
        test_block_boundaries();
        write_mode(1'b1);
        test_tail_lengths();
        test_abandon();
        write_mode(1'b0);
        test_random_messages(35);
        write_mode(1'b1);
        test_random_messages(35);
        write_mode(1'b0);
        test_random_messages(30);

        drain_block();
        done_sending = 1'b1;
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
